FILE: hw/rtl/tw_pkg.sv
// tw_pkg: types, codes and sizes shared by the timing wheel tracker
// no dependencies
`default_nettype none

package tw_pkg;
	localparam int MaxEntries = 64;
	localparam int IdxW       = 6;
	localparam int CntW       = 7;
	localparam int ConnW      = 16;
	localparam int SizeW      = 7;
	localparam logic [SizeW-1:0] SizeReset = 7'd30;
	localparam logic [SizeW-1:0] SizeMax   = 7'd64;

	typedef enum logic [1:0] {
		CMD_ADD     = 2'd0,
		CMD_REFRESH = 2'd1,
		CMD_DELETE  = 2'd2,
		CMD_TICK    = 2'd3
	} cmd_t;

	localparam logic [1:0] KIND_REPLY   = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_EMPTY   = 2'd2;

	typedef struct packed {
		logic             valid;
		logic [ConnW-1:0] conn;
		logic [IdxW-1:0]  slot;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic wr;
	} cell_ctl_t;
endpackage

`default_nettype wire

FILE: hw/rtl/tw_if.sv
// tw_if: request, response and configuration channel interfaces
// depends on tw_pkg
`default_nettype none

interface tw_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               command;
	logic [tw_pkg::ConnW-1:0] conn_id;
	logic [tw_pkg::IdxW-1:0]  slot_index;
	modport source (output valid, command, conn_id, slot_index, input ready);
	modport sink (input valid, command, conn_id, slot_index, output ready);
endinterface

interface tw_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               kind;
	logic [tw_pkg::IdxW-1:0]  slot_out;
	logic                     not_found;
	logic                     table_full;
	logic [tw_pkg::ConnW-1:0] expired_id;
	logic                     last;
	modport source (output valid, kind, slot_out, not_found, table_full, expired_id, last,
		input ready);
	modport sink (input valid, kind, slot_out, not_found, table_full, expired_id, last,
		output ready);
endinterface

interface tw_cfg_if;
	logic                     valid;
	logic                     ready;
	logic [tw_pkg::SizeW-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tw_cell.sv
// tw_cell: one entry of the age-ordered chain, shifts toward the head
// depends on tw_pkg
`default_nettype none

module tw_cell (
	input  wire                clk,
	input  wire                arst_n,
	input  tw_pkg::cell_ctl_t  ctl,
	input  tw_pkg::entry_t     nbr,
	input  tw_pkg::entry_t     wdata,
	output tw_pkg::entry_t     ent
);
	import tw_pkg::*;

	entry_t ent_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else if (ctl.wr) begin
			ent_q <= wdata;
		end else if (ctl.shift) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;
endmodule

`default_nettype wire

FILE: hw/rtl/timing_wheel_timeout_tracker.sv
// timing_wheel_timeout_tracker: timing wheel idle-timeout tracker, top level
// depends on tw_pkg, tw_if (tw_req_if, tw_rsp_if, tw_cfg_if) and tw_cell
//
//   channel | dir | moves
//   req     | in  | command, conn_id, slot_index
//   rsp     | out | kind, slot_out, not_found, table_full, expired_id, last
//   cfg     | in  | wheel_size write
//
// entries sit in a chain of 64 cells, oldest at the head, always packed
// add goes straight to the final write; refresh, delete and tick walk the chain once
// over the n stored entries, and a walk waits while rsp holds a reply not yet taken
// a wheel_size write holds off requests while the current slot is folded into range
// reset clears all cells at once; a request is not taken until the reply to the one before is loaded
`default_nettype none

module timing_wheel_timeout_tracker (
	input  wire clk,
	input  wire arst_n,
	tw_cfg_if.sink   cfg,
	tw_req_if.sink   req,
	tw_rsp_if.source rsp
);
	import tw_pkg::*;

	typedef enum logic [1:0] {IDLE, SCAN, FIN, SIZE} state_t;

	state_t           state_q;
	cmd_t             cmd_q;
	logic [ConnW-1:0] cid_q;
	logic [IdxW-1:0]  sidx_q;
	logic [IdxW-1:0]  cur_q;
	logic [SizeW-1:0] eff_q;
	logic [CntW-1:0]  count_q;
	logic [CntW-1:0]  rem_q;
	logic [CntW-1:0]  kept_q;
	logic             found_q;
	logic             pend_q;
	logic [ConnW-1:0] pid_q;

	logic             ov_q;
	logic [1:0]       kind_q;
	logic [IdxW-1:0]  slot_q;
	logic             nf_q;
	logic             full_q;
	logic [ConnW-1:0] xid_q;
	logic             last_q;

	entry_t    cell_ent [MaxEntries];
	cell_ctl_t cell_ctl [MaxEntries];
	entry_t    head;
	entry_t    wdata;
	logic      out_free;
	logic      step;
	logic      drop;
	logic      fin_wr;
	logic      fin_go;
	logic      load_rsp;
	logic [IdxW-1:0]  wptr;
	logic [IdxW-1:0]  newest;
	logic [IdxW-1:0]  next_cur;
	logic [SizeW-1:0] cfg_eff;
	logic [CntW-1:0]  wsum;

	logic [1:0]       fin_kind;
	logic [IdxW-1:0]  fin_slot;
	logic             fin_nf;
	logic             fin_full;
	logic [ConnW-1:0] fin_xid;
	logic [CntW-1:0]  fin_count;

	assign head     = cell_ent[0];
	assign out_free = !ov_q || rsp.ready;
	assign step     = (state_q == SCAN) && (rem_q != '0) && out_free;
	assign fin_go   = (state_q == FIN) && out_free;
	assign newest   = (cur_q == '0) ? IdxW'(eff_q - 7'd1) : cur_q - 6'd1;
	assign next_cur = ({1'b0, cur_q} + 7'd1 == eff_q) ? '0 : cur_q + 6'd1;
	assign cfg_eff  = (cfg.data == '0) ? 7'd1 : ((cfg.data > SizeMax) ? SizeMax : cfg.data);

	always_comb begin
		if (cmd_q == CMD_TICK) begin
			drop = head.valid && (head.slot == cur_q);
		end else begin
			drop = !found_q && head.valid && (head.slot == sidx_q) && (head.conn == cid_q);
		end
	end

	// an expired id goes out one drop late so the final one can carry last
	assign load_rsp = fin_go || (step && drop && (cmd_q == CMD_TICK) && pend_q);

	// fin writes: new entry for add, moved entry for a found refresh
	assign fin_wr = fin_go && (((cmd_q == CMD_ADD) && (count_q != CntW'(MaxEntries)))
		|| ((cmd_q == CMD_REFRESH) && found_q));

	always_comb begin
		fin_kind  = KIND_REPLY;
		fin_slot  = '0;
		fin_nf    = 1'b0;
		fin_full  = 1'b0;
		fin_xid   = '0;
		fin_count = count_q;
		case (cmd_q)
			CMD_ADD: begin
				if (count_q == CntW'(MaxEntries)) begin
					fin_full = 1'b1;
				end else begin
					fin_slot  = newest;
					fin_count = count_q + 7'd1;
				end
			end
			CMD_REFRESH: begin
				if (found_q) begin
					fin_slot  = newest;
					fin_count = kept_q + 7'd1;
				end else begin
					fin_nf = 1'b1;
				end
			end
			CMD_DELETE: begin
				fin_nf    = !found_q;
				fin_count = kept_q;
			end
			default: begin
				fin_count = kept_q;
				fin_slot  = cur_q;
				if (pend_q) begin
					fin_kind = KIND_EXPIRED;
					fin_xid  = pid_q;
				end else begin
					fin_kind = KIND_EMPTY;
				end
			end
		endcase
	end

	// kept entries land just behind the unwalked part of the chain
	always_comb begin
		wsum = rem_q - 7'd1 + kept_q;
		if (state_q == SCAN) begin
			wptr = wsum[IdxW-1:0];
		end else if (cmd_q == CMD_ADD) begin
			wptr = count_q[IdxW-1:0];
		end else begin
			wptr = kept_q[IdxW-1:0];
		end
		if (state_q == SCAN) begin
			wdata = head;
		end else begin
			wdata = '{valid: 1'b1, conn: cid_q, slot: newest};
		end
	end

	for (genvar i = 0; i < MaxEntries; i++) begin : g_cell
		entry_t nbr;
		if (i == MaxEntries - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = cell_ent[i+1];
		end
		assign cell_ctl[i].shift = step;
		assign cell_ctl[i].wr = (wptr == IdxW'(i)) && ((step && !drop) || fin_wr);
		tw_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.ctl   (cell_ctl[i]),
			.nbr   (nbr),
			.wdata (wdata),
			.ent   (cell_ent[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cmd_q   <= CMD_ADD;
			cid_q   <= '0;
			sidx_q  <= '0;
			cur_q   <= '0;
			eff_q   <= SizeReset;
			count_q <= '0;
			rem_q   <= '0;
			kept_q  <= '0;
			found_q <= 1'b0;
			pend_q  <= 1'b0;
			pid_q   <= '0;
			ov_q    <= 1'b0;
			kind_q  <= '0;
			slot_q  <= '0;
			nf_q    <= 1'b0;
			full_q  <= 1'b0;
			xid_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			if (load_rsp) begin
				ov_q <= 1'b1;
			end else if (rsp.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (cfg.valid) begin
						eff_q   <= cfg_eff;
						state_q <= SIZE;
					end else if (req.valid) begin
						cmd_q   <= cmd_t'(req.command);
						cid_q   <= req.conn_id;
						sidx_q  <= req.slot_index;
						rem_q   <= count_q;
						kept_q  <= '0;
						found_q <= 1'b0;
						pend_q  <= 1'b0;
						if (cmd_t'(req.command) == CMD_TICK) begin
							cur_q <= next_cur;
						end
						state_q <= (cmd_t'(req.command) == CMD_ADD) ? FIN : SCAN;
					end
				end
				SIZE: begin
					if ({1'b0, cur_q} >= eff_q) begin
						cur_q <= IdxW'({1'b0, cur_q} - eff_q);
					end else begin
						state_q <= IDLE;
					end
				end
				SCAN: begin
					if (rem_q == '0) begin
						state_q <= FIN;
					end else if (step) begin
						rem_q <= rem_q - 7'd1;
						if (!drop) begin
							kept_q <= kept_q + 7'd1;
						end else if (cmd_q == CMD_TICK) begin
							pend_q <= 1'b1;
							pid_q  <= head.conn;
							if (pend_q) begin
								kind_q <= KIND_EXPIRED;
								slot_q <= cur_q;
								nf_q   <= 1'b0;
								full_q <= 1'b0;
								xid_q  <= pid_q;
								last_q <= 1'b0;
							end
						end else begin
							found_q <= 1'b1;
						end
					end
				end
				FIN: begin
					if (fin_go) begin
						kind_q  <= fin_kind;
						slot_q  <= fin_slot;
						nf_q    <= fin_nf;
						full_q  <= fin_full;
						xid_q   <= fin_xid;
						last_q  <= 1'b1;
						count_q <= fin_count;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign req.ready      = (state_q == IDLE) && !cfg.valid;
	assign cfg.ready      = (state_q == IDLE);
	assign rsp.valid      = ov_q;
	assign rsp.kind       = kind_q;
	assign rsp.slot_out   = slot_q;
	assign rsp.not_found  = nf_q;
	assign rsp.table_full = full_q;
	assign rsp.expired_id = xid_q;
	assign rsp.last       = last_q;
endmodule

`default_nettype wire

FILE: dv/tb_top.sv
// tb_top: self-checking testbench for the timing wheel timeout tracker
// depends on tw_pkg, tw_if and timing_wheel_timeout_tracker
// an in-bench wheel predictor forecasts every reply and expiry, a monitor checks in order
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import tw_pkg::*;

	typedef struct {
		logic [1:0]       kind;
		logic [IdxW-1:0]  slot_out;
		logic             not_found;
		logic             table_full;
		logic [ConnW-1:0] expired_id;
		logic             last;
	} wheel_result_t;

	class wheel_scoreboard;
		bit               live[MaxEntries];
		logic [ConnW-1:0] conn[MaxEntries];
		logic [IdxW-1:0]  slot[MaxEntries];
		int unsigned      stamp[MaxEntries];
		int unsigned      size_reg;
		int unsigned      cur;
		int unsigned      counter;
		wheel_result_t    expected_q[$];
		int               errors;

		function new();
			size_reg = 32'(SizeReset);
			cur = 0;
			counter = 0;
			errors = 0;
			foreach (live[i]) live[i] = 0;
		endfunction

		function int unsigned span();
			if (size_reg == 0) return 1;
			if (size_reg > SizeMax) return 32'(SizeMax);
			return size_reg;
		endfunction

		function void write_size(int unsigned v);
			size_reg = v;
			cur = cur % span();
		endfunction

		// renumber live stamps in order when the counter runs out
		function int unsigned next_stamp();
			int unsigned rank[MaxEntries];
			int unsigned n;
			int unsigned s;
			if (counter >= 16'hffff) begin
				n = 0;
				foreach (live[i]) begin
					rank[i] = 0;
					if (!live[i]) continue;
					foreach (live[j])
						if (live[j] && stamp[j] < stamp[i]) rank[i]++;
					n++;
				end
				foreach (live[i]) if (live[i]) stamp[i] = rank[i];
				counter = n;
			end
			s = counter;
			counter = (counter + 1) & 16'hffff;
			return s;
		endfunction

		function int oldest_in(int unsigned s, bit match, logic [ConnW-1:0] c);
			int best;
			best = -1;
			foreach (live[i]) begin
				if (!live[i] || slot[i] != s) continue;
				if (match && conn[i] != c) continue;
				if (best < 0 || stamp[i] < stamp[best]) best = i;
			end
			return best;
		endfunction

		function void push(logic [1:0] k, int unsigned s, bit nf, bit full,
				logic [ConnW-1:0] id, bit lst);
			wheel_result_t r;
			r.kind = k;
			r.slot_out = IdxW'(s);
			r.not_found = nf;
			r.table_full = full;
			r.expired_id = id;
			r.last = lst;
			expected_q.push_back(r);
		endfunction

		function void note_request(cmd_t c, logic [ConnW-1:0] id, logic [IdxW-1:0] s);
			int e;
			int k;
			int unsigned n;
			n = span();
			e = -1;
			case (c)
				CMD_ADD: begin
					foreach (live[i]) if (!live[i] && e < 0) e = i;
					if (e < 0) begin
						push(KIND_REPLY, 0, 0, 1, 0, 1);
					end else begin
						stamp[e] = next_stamp();
						live[e] = 1;
						conn[e] = id;
						slot[e] = IdxW'((cur % n + n - 1) % n);
						push(KIND_REPLY, slot[e], 0, 0, 0, 1);
					end
				end
				CMD_REFRESH, CMD_DELETE: begin
					e = oldest_in(s, 1, id);
					if (e < 0) begin
						push(KIND_REPLY, 0, 1, 0, 0, 1);
					end else if (c == CMD_REFRESH) begin
						stamp[e] = next_stamp();
						slot[e] = IdxW'((cur % n + n - 1) % n);
						push(KIND_REPLY, slot[e], 0, 0, 0, 1);
					end else begin
						live[e] = 0;
						push(KIND_REPLY, 0, 0, 0, 0, 1);
					end
				end
				default: begin
					cur = (cur % n + 1) % n;
					k = 0;
					while (k < MaxEntries) begin
						e = oldest_in(cur, 0, 0);
						if (e < 0) break;
						live[e] = 0;
						push(KIND_EXPIRED, cur, 0, 0, conn[e], 0);
						k++;
					end
					if (k == 0) push(KIND_EMPTY, cur, 0, 0, 0, 1);
					else expected_q[$].last = 1;
				end
			endcase
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				$error("%s mismatch: expected %0h, actual %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(wheel_result_t got);
			wheel_result_t want;
			if (expected_q.size() == 0) begin
				$error("unexpected result: kind %0d id %0h", got.kind, got.expired_id);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("slot_out", want.slot_out, got.slot_out);
			compare_field("not_found", want.not_found, got.not_found);
			compare_field("table_full", want.table_full, got.table_full);
			compare_field("expired_id", want.expired_id, got.expired_id);
			compare_field("last", want.last, got.last);
		endfunction

		function bit pick_live(output logic [ConnW-1:0] c, output logic [IdxW-1:0] s);
			int idx[$];
			int p;
			foreach (live[i]) if (live[i]) idx.push_back(i);
			if (idx.size() == 0) return 0;
			p = idx[$urandom_range(0, idx.size() - 1)];
			c = conn[p];
			s = slot[p];
			return 1;
		endfunction
	endclass

	logic clk = 0;
	logic arst_n;
	int   snd_idle;
	int   rcv_idle;
	wheel_scoreboard sb;

	tw_req_if req_ch ();
	tw_rsp_if rsp_ch ();
	tw_cfg_if cfg_ch ();

	timing_wheel_timeout_tracker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rcv_idle);
	end

	always @(posedge clk) begin
		wheel_result_t got;
		if (arst_n && sb != null && rsp_ch.valid && rsp_ch.ready) begin
			got.kind = rsp_ch.kind;
			got.slot_out = rsp_ch.slot_out;
			got.not_found = rsp_ch.not_found;
			got.table_full = rsp_ch.table_full;
			got.expired_id = rsp_ch.expired_id;
			got.last = rsp_ch.last;
			sb.check_result(got);
		end
	end

	// valid stays high between back-to-back requests
	task automatic send_request(cmd_t c, logic [ConnW-1:0] id, logic [IdxW-1:0] s);
		if ($urandom_range(0, 99) < snd_idle) begin
			req_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.command <= c;
		req_ch.conn_id <= id;
		req_ch.slot_index <= s;
		do @(posedge clk); while (!req_ch.ready);
		sb.note_request(c, id, s);
	endtask

	task automatic drain_wheel();
		req_ch.valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic write_wheel_size(logic [SizeW-1:0] v);
		drain_wheel();
		cfg_ch.valid <= 1;
		cfg_ch.data <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
		sb.write_size(v);
	endtask

	task automatic run_random(int count, int add_pct, int rfr_pct, int del_pct);
		int               roll;
		logic [ConnW-1:0] id;
		logic [IdxW-1:0]  s;
		cmd_t             c;
		for (int n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			id = ConnW'($urandom);
			s = IdxW'($urandom_range(0, 63));
			if (roll < add_pct) c = CMD_ADD;
			else if (roll < add_pct + rfr_pct) c = CMD_REFRESH;
			else if (roll < add_pct + rfr_pct + del_pct) c = CMD_DELETE;
			else c = CMD_TICK;
			// mostly target a live entry so refresh and delete hit
			if ((c == CMD_REFRESH || c == CMD_DELETE) && $urandom_range(0, 9) < 8)
				void'(sb.pick_live(id, s));
			send_request(c, id, s);
			if (n == count / 2) drain_wheel();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 0;
		req_ch.valid = 0;
		req_ch.command = CMD_ADD;
		req_ch.conn_id = 0;
		req_ch.slot_index = 0;
		cfg_ch.valid = 0;
		cfg_ch.data = 0;
		rsp_ch.ready = 0;
		snd_idle = 21;
		rcv_idle = 74;
		repeat (10) @(posedge clk);
		arst_n <= 1;

		// directed: extremes, duplicates, misses, out-of-range slot, size rewrite
		send_request(CMD_ADD, 16'h0000, 0);
		send_request(CMD_ADD, 16'hffff, 0);
		send_request(CMD_ADD, 16'h1234, 0);
		send_request(CMD_ADD, 16'h1234, 0);
		send_request(CMD_REFRESH, 16'h1234, 29);
		send_request(CMD_REFRESH, 16'h5555, 29);
		send_request(CMD_REFRESH, 16'h0000, 63);
		send_request(CMD_DELETE, 16'hffff, 29);
		send_request(CMD_DELETE, 16'hffff, 29);
		send_request(CMD_TICK, 16'h0000, 0);
		send_request(CMD_ADD, 16'haaaa, 63);
		write_wheel_size(1);
		send_request(CMD_ADD, 16'h00ff, 0);
		send_request(CMD_ADD, 16'hff00, 0);
		send_request(CMD_ADD, 16'h00ff, 0);
		send_request(CMD_TICK, 16'h0000, 0);
		send_request(CMD_TICK, 16'h0000, 0);
		send_request(CMD_REFRESH, 16'h1234, 29);
		send_request(CMD_DELETE, 16'h0000, 29);
		send_request(CMD_TICK, 16'h0000, 0);

		write_wheel_size(64);
		run_random(75, 85, 5, 5);
		write_wheel_size(127);
		run_random(10, 40, 30, 10);
		snd_idle = 74;
		rcv_idle = 21;
		write_wheel_size(0);
		run_random(20, 20, 40, 10);
		snd_idle = 0;
		rcv_idle = 0;
		write_wheel_size(SizeW'($urandom_range(2, 8)));
		run_random(25, 35, 20, 15);

		drain_wheel();
		if (sb.errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end
endmodule

`default_nettype wire
